/* sv/lrip_pkg.sv */
// shared types, constants and the arctangent table of the lidar range image projection
package lrip_pkg;

  localparam int COORD_W = 18;
  localparam int SQ_W = 36;
  localparam int HROOT_W = 26;
  localparam int RROOT_W = 18;
  localparam int CV_W = 29;
  localparam int ANG_W = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 18;
  localparam int QUEUE_DEPTH = 4;
  localparam int RANGE_W = 18;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLUMNS = 4096;
  localparam int DEF_CORDIC_STAGES = 16;

  localparam int ANG_PI = 205887;
  localparam int ANG_HALF_PI = 102944;

  localparam logic [6:0] RST_ROW_COUNT = 7'd16;
  localparam logic [12:0] RST_COLUMN_COUNT = 13'd1800;
  localparam logic [15:0] RST_ROWS_PER_RAD = 16'd1833;
  localparam logic [15:0] RST_COLS_PER_RAD = 16'd18335;
  localparam logic [15:0] RST_ELEV_OFFSET = 16'd17272;
  localparam logic [17:0] RST_MIN_RANGE = 18'd1024;
  localparam logic [17:0] RST_RANGE_CEIL = 18'd25600;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 3'd0,
    REG_COLUMN_COUNT = 3'd1,
    REG_ROWS_PER_RAD = 3'd2,
    REG_COLS_PER_RAD = 3'd3,
    REG_ELEV_OFFSET = 3'd4,
    REG_MIN_RANGE = 3'd5,
    REG_RANGE_CEIL = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_ROW = 2'd1,
    ST_COL = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    logic [6:0] row_count;
    logic [12:0] column_count;
    logic [15:0] rows_per_radian;
    logic [15:0] columns_per_radian;
    logic [15:0] elevation_offset;
    logic [17:0] min_range;
    logic [17:0] range_ceil;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic [SQ_W-1:0] hsq;
    logic [SQ_W-1:0] rsq;
  } pt_t;

  function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
    logic signed [ANG_W-1:0] v;
    case (i)
      0: v = 20'sd51472;
      1: v = 20'sd30386;
      2: v = 20'sd16055;
      3: v = 20'sd8150;
      4: v = 20'sd4091;
      5: v = 20'sd2047;
      6: v = 20'sd1024;
      7: v = 20'sd512;
      8: v = 20'sd256;
      9: v = 20'sd128;
      10: v = 20'sd64;
      11: v = 20'sd32;
      12: v = 20'sd16;
      13: v = 20'sd8;
      14: v = 20'sd4;
      15: v = 20'sd2;
      16: v = 20'sd1;
      default: v = 20'sd0;
    endcase
    return v;
  endfunction

endpackage

/* sv/lrip_if.sv */
// channel interfaces: point request, result request and register write
interface lrip_pt_if;
  import lrip_pkg::*;
  logic valid;
  logic ready;
  logic signed [COORD_W-1:0] point_x;
  logic signed [COORD_W-1:0] point_y;
  logic signed [COORD_W-1:0] point_z;
  modport source(output valid, point_x, point_y, point_z, input ready);
  modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface lrip_res_if;
  logic valid;
  logic ready;
  logic [5:0] row_index;
  logic [11:0] column_index;
  logic [17:0] pixel_index;
  logic [17:0] point_range;
  logic [1:0] status;
  modport source(output valid, row_index, column_index, pixel_index, point_range, status,
                 input ready);
  modport sink(input valid, row_index, column_index, pixel_index, point_range, status,
               output ready);
endinterface

interface lrip_cfg_if;
  import lrip_pkg::*;
  logic valid;
  logic ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* sv/lrip_front.sv */
// front end: register file, point intake and squared distances
module lrip_front import lrip_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lrip_pt_if.sink in_ch,
  lrip_cfg_if.sink cfg_ch,
  output logic fq_valid,
  output pt_t  fq_data,
  input  logic fq_ready,
  output cfg_t cfg
);

  cfg_t cfg_r;
  logic fv_r;
  pt_t fd_r;
  logic in_acc;
  logic signed [2*COORD_W-1:0] xx, yy, zz;
  logic [SQ_W-1:0] hsq;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count <= RST_ROW_COUNT;
      cfg_r.column_count <= RST_COLUMN_COUNT;
      cfg_r.rows_per_radian <= RST_ROWS_PER_RAD;
      cfg_r.columns_per_radian <= RST_COLS_PER_RAD;
      cfg_r.elevation_offset <= RST_ELEV_OFFSET;
      cfg_r.min_range <= RST_MIN_RANGE;
      cfg_r.range_ceil <= RST_RANGE_CEIL;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_ROW_COUNT: cfg_r.row_count <= cfg_ch.data[6:0];
        REG_COLUMN_COUNT: cfg_r.column_count <= cfg_ch.data[12:0];
        REG_ROWS_PER_RAD: cfg_r.rows_per_radian <= cfg_ch.data[15:0];
        REG_COLS_PER_RAD: cfg_r.columns_per_radian <= cfg_ch.data[15:0];
        REG_ELEV_OFFSET: cfg_r.elevation_offset <= cfg_ch.data[15:0];
        REG_MIN_RANGE: cfg_r.min_range <= cfg_ch.data[17:0];
        REG_RANGE_CEIL: cfg_r.range_ceil <= cfg_ch.data[17:0];
        default: cfg_r <= cfg_r;
      endcase
    end
  end

  assign in_ch.ready = !fv_r || fq_ready;
  assign in_acc = in_ch.valid && in_ch.ready;

  assign xx = in_ch.point_x * in_ch.point_x;
  assign yy = in_ch.point_y * in_ch.point_y;
  assign zz = in_ch.point_z * in_ch.point_z;
  assign hsq = SQ_W'(unsigned'(xx)) + SQ_W'(unsigned'(yy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_acc) begin
      fv_r <= 1'b1;
    end else if (fq_ready) begin
      fv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      fd_r.x <= in_ch.point_x;
      fd_r.y <= in_ch.point_y;
      fd_r.z <= in_ch.point_z;
      fd_r.hsq <= hsq;
      fd_r.rsq <= hsq + SQ_W'(unsigned'(zz));
    end
  end

  assign fq_valid = fv_r;
  assign fq_data = fd_r;

endmodule

/* sv/lrip_queue.sv */
// short request queue between front and back end
module lrip_queue import lrip_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  pt_t  push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output pt_t  pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pt_t mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic push, pop;

  assign push_ready = count_r != CNT_W'(QUEUE_DEPTH);
  assign pop_valid = count_r != '0;
  assign push = push_valid && push_ready;
  assign pop = pop_valid && pop_ready;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      if (push && !pop) count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

/* sv/lrip_back.sv */
// back end: root pipelines, cordic pipelines, scaling and image checks
module lrip_back import lrip_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_valid,
  output logic q_pop,
  input  pt_t  q_data,
  lrip_res_if.source out_ch
);

  localparam int ROW_W = $clog2(MAX_ROWS + 1);
  localparam int COL_W = $clog2(MAX_COLUMNS + 1);
  localparam int SQH_W = 2 * HROOT_W;
  localparam int SQR_W = 2 * RROOT_W;
  localparam int SUM_W = ANG_W + 1;
  localparam int PROD_W = SUM_W + 17;
  localparam int ROWV_W = 16;
  localparam int COLV_W = 20;
  localparam int RND_W = PROD_W - 21;
  localparam int PIX_W = (ROW_W + COL_W + 1 > 18) ? ROW_W + COL_W + 1 : 18;

  logic en;
  logic [ROW_W-1:0] rows_eff;
  logic [COL_W-1:0] cols_eff;

  assign rows_eff = (32'(cfg.row_count) > 32'(MAX_ROWS)) ? ROW_W'(MAX_ROWS)
                                                          : ROW_W'(cfg.row_count);
  assign cols_eff = (32'(cfg.column_count) > 32'(MAX_COLUMNS)) ? COL_W'(MAX_COLUMNS)
                                                                : COL_W'(cfg.column_count);

  // root pipeline: horizontal distance times 256 and range, one bit a stage
  logic sv_i [HROOT_W];
  logic sv_r [HROOT_W];
  logic signed [COORD_W-1:0] sx_i [HROOT_W], sy_i [HROOT_W], sz_i [HROOT_W];
  logic signed [COORD_W-1:0] sx_r [HROOT_W], sy_r [HROOT_W], sz_r [HROOT_W];
  logic [SQH_W-1:0] hrem_i [HROOT_W], hrem_r [HROOT_W];
  logic [HROOT_W-1:0] hroot_i [HROOT_W], hroot_r [HROOT_W];
  logic [SQR_W-1:0] rrem_i [HROOT_W], rrem_r [HROOT_W];
  logic [RROOT_W-1:0] rroot_i [HROOT_W], rroot_r [HROOT_W];

  assign q_pop = q_valid && en;

  for (genvar s = 0; s < HROOT_W; s++) begin : g_sq
    localparam int KH = HROOT_W - 1 - s;
    logic [SQH_W-1:0] th;

    if (s == 0) begin : g_head
      assign sv_i[s] = q_valid;
      assign sx_i[s] = q_data.x;
      assign sy_i[s] = q_data.y;
      assign sz_i[s] = q_data.z;
      assign hrem_i[s] = {q_data.hsq[SQH_W-17:0], 16'b0};
      assign hroot_i[s] = '0;
      assign rrem_i[s] = q_data.rsq;
      assign rroot_i[s] = '0;
    end else begin : g_link
      assign sv_i[s] = sv_r[s-1];
      assign sx_i[s] = sx_r[s-1];
      assign sy_i[s] = sy_r[s-1];
      assign sz_i[s] = sz_r[s-1];
      assign hrem_i[s] = hrem_r[s-1];
      assign hroot_i[s] = hroot_r[s-1];
      assign rrem_i[s] = rrem_r[s-1];
      assign rroot_i[s] = rroot_r[s-1];
    end

    assign th = (SQH_W'(hroot_i[s]) << (KH + 1)) + (SQH_W'(1) << (2 * KH));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv_r[s] <= 1'b0;
      end else if (en) begin
        sv_r[s] <= sv_i[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sx_r[s] <= sx_i[s];
        sy_r[s] <= sy_i[s];
        sz_r[s] <= sz_i[s];
        if (hrem_i[s] >= th) begin
          hrem_r[s] <= hrem_i[s] - th;
          hroot_r[s] <= hroot_i[s] | (HROOT_W'(1) << KH);
        end else begin
          hrem_r[s] <= hrem_i[s];
          hroot_r[s] <= hroot_i[s];
        end
      end
    end

    if (s < RROOT_W) begin : g_rng
      localparam int KR = RROOT_W - 1 - s;
      logic [SQR_W-1:0] tr;
      assign tr = (SQR_W'(rroot_i[s]) << (KR + 1)) + (SQR_W'(1) << (2 * KR));
      always_ff @(posedge clk) begin
        if (en) begin
          if (rrem_i[s] >= tr) begin
            rrem_r[s] <= rrem_i[s] - tr;
            rroot_r[s] <= rroot_i[s] | (RROOT_W'(1) << KR);
          end else begin
            rrem_r[s] <= rrem_i[s];
            rroot_r[s] <= rroot_i[s];
          end
        end
      end
    end else begin : g_rng_pass
      always_ff @(posedge clk) begin
        if (en) begin
          rrem_r[s] <= rrem_i[s];
          rroot_r[s] <= rroot_i[s];
        end
      end
    end
  end

  // cordic pipelines: elevation and azimuth side by side
  localparam int LS = HROOT_W - 1;

  logic cv_r [CORDIC_STAGES+1];
  logic signed [CV_W-1:0] ea_r [CORDIC_STAGES+1], eb_r [CORDIC_STAGES+1];
  logic signed [CV_W-1:0] aa_r [CORDIC_STAGES+1], ab_r [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0] eang_r [CORDIC_STAGES+1], aang_r [CORDIC_STAGES+1];
  logic ezero_r [CORDIC_STAGES+1], azero_r [CORDIC_STAGES+1];
  logic [RANGE_W-1:0] crng_r [CORDIC_STAGES+1];

  logic signed [CV_W-1:0] pa0, pb0;

  assign pa0 = CV_W'(signed'({sx_r[LS], 8'b0}));
  assign pb0 = CV_W'(signed'({sy_r[LS], 8'b0}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else if (en) begin
      cv_r[0] <= sv_r[LS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea_r[0] <= CV_W'(signed'({sz_r[LS], 8'b0}));
      eb_r[0] <= signed'(CV_W'(hroot_r[LS]));
      eang_r[0] <= '0;
      ezero_r[0] <= (sz_r[LS] == '0) && (hroot_r[LS] == '0);
      azero_r[0] <= (sx_r[LS] == '0) && (sy_r[LS] == '0);
      crng_r[0] <= rroot_r[LS];
      if (pb0 < 0) begin
        aa_r[0] <= -pa0;
        ab_r[0] <= -pb0;
        aang_r[0] <= (pa0 >= 0) ? ANG_W'(ANG_PI) : -ANG_W'(ANG_PI);
      end else begin
        aa_r[0] <= pa0;
        ab_r[0] <= pb0;
        aang_r[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cr
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else if (en) begin
        cv_r[i+1] <= cv_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ezero_r[i+1] <= ezero_r[i];
        azero_r[i+1] <= azero_r[i];
        crng_r[i+1] <= crng_r[i];
        if (ea_r[i] >= 0) begin
          eb_r[i+1] <= eb_r[i] + (ea_r[i] >>> i);
          ea_r[i+1] <= ea_r[i] - (eb_r[i] >>> i);
          eang_r[i+1] <= eang_r[i] + atan_entry(i);
        end else begin
          eb_r[i+1] <= eb_r[i] - (ea_r[i] >>> i);
          ea_r[i+1] <= ea_r[i] + (eb_r[i] >>> i);
          eang_r[i+1] <= eang_r[i] - atan_entry(i);
        end
        if (aa_r[i] >= 0) begin
          ab_r[i+1] <= ab_r[i] + (aa_r[i] >>> i);
          aa_r[i+1] <= aa_r[i] - (ab_r[i] >>> i);
          aang_r[i+1] <= aang_r[i] + atan_entry(i);
        end else begin
          ab_r[i+1] <= ab_r[i] - (aa_r[i] >>> i);
          aa_r[i+1] <= aa_r[i] + (ab_r[i] >>> i);
          aang_r[i+1] <= aang_r[i] - atan_entry(i);
        end
      end
    end
  end

  // scaling multiplies
  localparam int LC = CORDIC_STAGES;

  logic signed [ANG_W-1:0] elev, azim;
  logic signed [SUM_W-1:0] esum, adif;
  logic ma_v_r;
  logic signed [PROD_W-1:0] rprod_r, cprod_r;
  logic [RANGE_W-1:0] ma_rng_r;

  assign elev = ezero_r[LC] ? '0 : eang_r[LC];
  assign azim = azero_r[LC] ? '0 : aang_r[LC];
  assign esum = SUM_W'(elev) + signed'(SUM_W'(cfg.elevation_offset));
  assign adif = SUM_W'(azim) - SUM_W'(ANG_HALF_PI);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ma_v_r <= 1'b0;
    end else if (en) begin
      ma_v_r <= cv_r[LC];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rprod_r <= esum * signed'({1'b0, cfg.rows_per_radian});
      cprod_r <= adif * signed'({1'b0, cfg.columns_per_radian});
      ma_rng_r <= crng_r[LC];
    end
  end

  // row truncation, column rounding and halving
  logic rneg, cneg;
  logic [PROD_W-1:0] rmag, cmag, rq, cq;
  logic [RND_W-1:0] rr;
  logic signed [COLV_W-1:0] ecol, ecol_mag;
  logic signed [ROWV_W-1:0] row_nxt;
  logic signed [COLV_W-1:0] col_nxt;
  logic mb_v_r;
  logic signed [ROWV_W-1:0] row_r;
  logic signed [COLV_W-1:0] col_r;
  logic [RANGE_W-1:0] mb_rng_r;

  assign rneg = rprod_r < 0;
  assign cneg = cprod_r < 0;
  assign rmag = rneg ? unsigned'(-rprod_r) : unsigned'(rprod_r);
  assign cmag = cneg ? unsigned'(-cprod_r) : unsigned'(cprod_r);
  assign rq = rmag >> 22;
  assign cq = (cmag + (PROD_W'(1) << 21)) >> 22;
  assign rr = cq[RND_W-1:0];
  assign row_nxt = rneg ? -signed'(ROWV_W'(rq)) : signed'(ROWV_W'(rq));
  assign ecol = cneg ? signed'(COLV_W'(cols_eff)) + signed'(COLV_W'({rr, 1'b0}))
                     : signed'(COLV_W'(cols_eff)) - signed'(COLV_W'({rr, 1'b0}));
  assign ecol_mag = -ecol;
  assign col_nxt = (ecol >= 0) ? (ecol >>> 1) : -(ecol_mag >>> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mb_v_r <= 1'b0;
    end else if (en) begin
      mb_v_r <= ma_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
      mb_rng_r <= ma_rng_r;
    end
  end

  // wrap, checks and pixel index
  logic signed [COLV_W-1:0] cols_s, colw;
  logic signed [ROWV_W-1:0] rows_s;
  status_t st;
  logic [PIX_W-1:0] pix;
  logic o_v_r;
  logic [5:0] o_row_r;
  logic [11:0] o_col_r;
  logic [17:0] o_pix_r;
  logic [RANGE_W-1:0] o_rng_r;
  status_t o_st_r;

  assign cols_s = signed'(COLV_W'(cols_eff));
  assign rows_s = signed'(ROWV_W'(rows_eff));
  assign colw = (col_r >= cols_s) ? col_r - cols_s : col_r;
  assign pix = PIX_W'(colw[COL_W-1:0]) + PIX_W'(row_r[ROW_W-1:0]) * PIX_W'(cols_eff);

  always_comb begin
    priority if (row_r < 0 || row_r >= rows_s) begin
      st = ST_ROW;
    end else if (colw < 0 || colw >= cols_s) begin
      st = ST_COL;
    end else if (mb_rng_r < cfg.min_range || mb_rng_r > cfg.range_ceil) begin
      st = ST_RANGE;
    end else begin
      st = ST_OK;
    end
  end

  assign en = !o_v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_v_r <= 1'b0;
    end else if (en) begin
      o_v_r <= mb_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_st_r <= st;
      o_rng_r <= mb_rng_r;
      if (st == ST_OK) begin
        o_row_r <= 6'(row_r);
        o_col_r <= 12'(colw);
        o_pix_r <= pix[17:0];
      end else begin
        o_row_r <= '0;
        o_col_r <= '0;
        o_pix_r <= '0;
      end
    end
  end

  assign out_ch.valid = o_v_r;
  assign out_ch.row_index = o_row_r;
  assign out_ch.column_index = o_col_r;
  assign out_ch.pixel_index = o_pix_r;
  assign out_ch.point_range = o_rng_r;
  assign out_ch.status = o_st_r;

endmodule

/* sv/lidar_range_image_projection_top.sv */
// Projects lidar points onto a spherical range image. One point is taken each clock cycle and
// one result leaves each cycle while the result side keeps ready high. A point passes
// through the front register, the queue, the 26-stage square root of the horizontal distance
// (one bit a stage), the CORDIC pipeline and the scaling, rounding and output registers.
// A four-entry queue lets the intake keep taking points through short stalls of the result
// side; once it fills, in_ch.ready drops. Registers are written through cfg_ch, which is
// always ready, and should be written only while no point is in flight.
module lidar_range_image_projection_top import lrip_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
  parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
  input  logic clk,
  input  logic rst_n,
  lrip_pt_if.sink in_ch,
  lrip_res_if.source out_ch,
  lrip_cfg_if.sink cfg_ch
);

  cfg_t cfg;
  logic fq_valid, fq_ready;
  pt_t fq_data;
  logic q_valid, q_pop;
  pt_t q_data;

  lrip_front u_front (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .cfg_ch(cfg_ch),
    .fq_valid(fq_valid),
    .fq_data(fq_data),
    .fq_ready(fq_ready),
    .cfg(cfg)
  );

  lrip_queue u_queue (
    .clk(clk),
    .rst_n(rst_n),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_data(fq_data),
    .pop_valid(q_valid),
    .pop_ready(q_pop),
    .pop_data(q_data)
  );

  lrip_back #(
    .MAX_ROWS(MAX_ROWS),
    .MAX_COLUMNS(MAX_COLUMNS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_back (
    .clk(clk),
    .rst_n(rst_n),
    .cfg(cfg),
    .q_valid(q_valid),
    .q_pop(q_pop),
    .q_data(q_data),
    .out_ch(out_ch)
  );

endmodule

/* sv/lrip_checker.sv */
// port checks of the lidar range image projection and their binding
module lrip_checker import lrip_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [5:0] out_row,
  input logic [11:0] out_col,
  input logic [17:0] out_pix,
  input logic [1:0] out_status
);

  logic [7:0] pending_r;
  logic in_acc, out_acc;

  assign in_acc = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else if (in_acc && !out_acc) begin
      pending_r <= pending_r + 8'd1;
    end else if (out_acc && !in_acc) begin
      pending_r <= pending_r - 8'd1;
    end
  end

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_row == '0 && out_col == '0 && out_pix == '0)
    else $error("rejected point carries image position");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc |-> pending_r != 8'd0)
    else $error("result without a pending point");

endmodule

bind lidar_range_image_projection_top lrip_checker u_lrip_checker (
  .clk(clk),
  .rst_n(rst_n),
  .in_valid(in_ch.valid),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_row(out_ch.row_index),
  .out_col(out_ch.column_index),
  .out_pix(out_ch.pixel_index),
  .out_status(out_ch.status)
);

/* dv/tb_lidar_range_image_projection_top.sv */
// self-checking testbench of the lidar range image projection top level
module tb_lidar_range_image_projection_top;
  import lrip_pkg::*;

  localparam cfg_reg_t REG_UNUSED = cfg_reg_t'(3'd7);
  localparam longint ROW_SCALE = 64'd4194304;
  localparam longint RANGE_CAP = 64'd262143;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct {
    logic [5:0] row_index;
    logic [11:0] column_index;
    logic [17:0] pixel_index;
    logic [17:0] point_range;
    status_t status;
  } projection_t;

  logic clk;
  logic rst_n;
  lrip_pt_if pt_ch();
  lrip_res_if res_ch();
  lrip_cfg_if cfg_bus();

  lidar_range_image_projection_top dut (
    .clk(clk), .rst_n(rst_n), .in_ch(pt_ch), .out_ch(res_ch), .cfg_ch(cfg_bus)
  );

  cfg_t image_cfg;
  projection_t pending_projections[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_request = 0;
  int hold_left = 0;

  const longint atan_steps[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                                   256, 128, 64, 32, 16, 8, 4, 2};

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned b = 64'h1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint a, longint b);
    longint ang = 0;
    longint na, nb;
    if (a == 0 && b == 0) return 0;
    if (b < 0) begin
      ang = (a >= 0) ? ANG_PI : -ANG_PI;
      a = -a;
      b = -b;
    end
    for (int i = 0; i < DEF_CORDIC_STAGES; i++) begin
      if (a >= 0) begin
        nb = b + (a >>> i);
        na = a - (b >>> i);
        ang += atan_steps[i];
      end else begin
        nb = b - (a >>> i);
        na = a + (b >>> i);
        ang -= atan_steps[i];
      end
      a = na;
      b = nb;
    end
    return ang;
  endfunction

  function automatic projection_t project_point(logic signed [17:0] px, logic signed [17:0] py,
                                                logic signed [17:0] pz);
    projection_t p;
    longint x = px;
    longint y = py;
    longint z = pz;
    longint unsigned hsq = x * x + y * y;
    longint unsigned rng = int_sqrt(hsq + z * z);
    longint rows = (image_cfg.row_count > DEF_MAX_ROWS) ? DEF_MAX_ROWS : image_cfg.row_count;
    longint cols = (image_cfg.column_count > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS
                                                                : image_cfg.column_count;
    longint h256 = int_sqrt(hsq << 16);
    longint elev, az, row, col, d, r, mag;
    if (rng > RANGE_CAP) rng = RANGE_CAP;
    elev = vector_angle(z * 256, h256);
    row = ((elev + longint'(image_cfg.elevation_offset)) *
           longint'(image_cfg.rows_per_radian)) / ROW_SCALE;
    az = vector_angle(x * 256, y * 256);
    d = (az - ANG_HALF_PI) * longint'(image_cfg.columns_per_radian);
    mag = d < 0 ? -d : d;
    r = (mag + (64'sd1 <<< 21)) >>> 22;
    if (d < 0) r = -r;
    col = (cols - 2 * r) / 2;
    if (col >= cols) col -= cols;
    if (row < 0 || row >= rows) p.status = ST_ROW;
    else if (col < 0 || col >= cols) p.status = ST_COL;
    else if (rng < image_cfg.min_range || rng > image_cfg.range_ceil) p.status = ST_RANGE;
    else p.status = ST_OK;
    if (p.status == ST_OK) begin
      p.row_index = row[5:0];
      p.column_index = col[11:0];
      p.pixel_index = 18'(col + row * cols);
    end else begin
      p.row_index = '0;
      p.column_index = '0;
      p.pixel_index = '0;
    end
    p.point_range = rng[17:0];
    return p;
  endfunction

  // result side: ready with random idling and a long hold-off on demand
  always @(posedge clk) begin
    if (!rst_n) begin
      res_ch.ready <= 1'b0;
    end else if (hold_request && hold_left == 0) begin
      hold_left <= 400;
      res_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ch.ready <= (hold_left == 1);
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    projection_t exp_p;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (pending_projections.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: status %0d", res_ch.status);
      end else begin
        exp_p = pending_projections[0];
        pending_projections.delete(0);
        if (res_ch.row_index !== exp_p.row_index || res_ch.column_index !== exp_p.column_index
            || res_ch.pixel_index !== exp_p.pixel_index
            || res_ch.point_range !== exp_p.point_range || res_ch.status !== exp_p.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                     exp_p.row_index, exp_p.column_index, exp_p.pixel_index,
                     exp_p.point_range, exp_p.status, res_ch.row_index, res_ch.column_index,
                     res_ch.pixel_index, res_ch.point_range, res_ch.status);
        end
      end
    end
  end

  task automatic send_point(logic signed [17:0] x, logic signed [17:0] y, logic signed [17:0] z);
    while ($urandom_range(99) < send_idle_pct) begin
      pt_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pt_ch.valid <= 1'b1;
    pt_ch.point_x <= x;
    pt_ch.point_y <= y;
    pt_ch.point_z <= z;
    do @(posedge clk); while (!pt_ch.ready);
    pending_projections = {pending_projections, project_point(x, y, z)};
  endtask

  task automatic drain();
    pt_ch.valid <= 1'b0;
    @(posedge clk);
    wait (pending_projections.size() == 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [17:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      REG_ROW_COUNT: image_cfg.row_count = value[6:0];
      REG_COLUMN_COUNT: image_cfg.column_count = value[12:0];
      REG_ROWS_PER_RAD: image_cfg.rows_per_radian = value[15:0];
      REG_COLS_PER_RAD: image_cfg.columns_per_radian = value[15:0];
      REG_ELEV_OFFSET: image_cfg.elevation_offset = value[15:0];
      REG_MIN_RANGE: image_cfg.min_range = value;
      REG_RANGE_CEIL: image_cfg.range_ceil = value;
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic restore_defaults();
    write_reg(REG_ROW_COUNT, RST_ROW_COUNT);
    write_reg(REG_COLUMN_COUNT, RST_COLUMN_COUNT);
    write_reg(REG_ROWS_PER_RAD, RST_ROWS_PER_RAD);
    write_reg(REG_COLS_PER_RAD, RST_COLS_PER_RAD);
    write_reg(REG_ELEV_OFFSET, RST_ELEV_OFFSET);
    write_reg(REG_MIN_RANGE, RST_MIN_RANGE);
    write_reg(REG_RANGE_CEIL, RST_RANGE_CEIL);
  endtask

  // mostly points within 25000 in x and y and 4000 in z, some over the full coordinate range
  task automatic send_random_point();
    if ($urandom_range(3) == 0)
      send_point(18'($urandom), 18'($urandom), 18'($urandom));
    else
      send_point(18'(int'($urandom_range(50000)) - 25000),
                 18'(int'($urandom_range(50000)) - 25000),
                 18'(int'($urandom_range(8000)) - 4000));
  endtask

  task automatic test_directed();
    send_point(0, 0, 0);
    send_point(18'sh1FFFF, 18'sh1FFFF, 18'sh1FFFF);
    send_point(-18'sh20000, -18'sh20000, -18'sh20000);
    send_point(18'sh1FFFF, -18'sh20000, 0);
    send_point(0, 0, 5000);
    send_point(0, 0, -5000);
    send_point(0, 10000, 0);
    send_point(0, -10000, 0);
    send_point(10000, 0, 0);
    send_point(-10000, 0, 0);
    send_point(-1, -10000, 100);
    send_point(1, -10000, -100);
    send_point(1024, 0, 0);
    send_point(1023, 0, 0);
    send_point(25600, 0, 0);
    send_point(25601, 0, 0);
    send_point(3000, 4000, -800);
    send_point(-7000, 2000, 1500);
    send_point(0, 0, -18'sh20000);
    send_point(5, -3, 1);
    drain();
  endtask

  task automatic run_phase(int n);
    repeat (n) send_random_point();
    drain();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_ROW_COUNT, 0);
    run_phase(10);
    write_reg(REG_ROW_COUNT, 7'h7F);
    write_reg(REG_COLUMN_COUNT, 0);
    run_phase(10);
    write_reg(REG_COLUMN_COUNT, 13'h1FFF);
    write_reg(REG_ROWS_PER_RAD, 16'hFFFF);
    write_reg(REG_COLS_PER_RAD, 1);
    write_reg(REG_ELEV_OFFSET, 16'hFFFF);
    write_reg(REG_MIN_RANGE, 0);
    write_reg(REG_RANGE_CEIL, 18'h3FFFF);
    run_phase(30);
    write_reg(REG_ROW_COUNT, 1);
    write_reg(REG_COLUMN_COUNT, 1);
    write_reg(REG_ROWS_PER_RAD, 1);
    write_reg(REG_COLS_PER_RAD, 16'hFFFF);
    write_reg(REG_ELEV_OFFSET, 0);
    run_phase(30);
    write_reg(REG_ROW_COUNT, 64);
    write_reg(REG_COLUMN_COUNT, 4096);
    write_reg(REG_ROWS_PER_RAD, 8000);
    write_reg(REG_COLS_PER_RAD, 40000);
    write_reg(REG_ELEV_OFFSET, 30000);
    write_reg(REG_MIN_RANGE, 30000);
    write_reg(REG_RANGE_CEIL, 20000);
    run_phase(20);
    write_reg(REG_UNUSED, 18'h3FFFF);
    write_reg(REG_MIN_RANGE, 18'h3FFFF);
    write_reg(REG_RANGE_CEIL, 18'h3FFFF);
    run_phase(20);
    restore_defaults();
  endtask

  task automatic test_random_traffic();
    send_idle_pct = 29;
    recv_idle_pct = 88;
    run_phase(180);
    send_idle_pct = 88;
    recv_idle_pct = 29;
    run_phase(180);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(180);
  endtask

  task automatic test_backpressure();
    hold_request = 1;
    wait (hold_left > 0);
    hold_request = 0;
    repeat (120) send_random_point();
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    pt_ch.valid = 1'b0;
    pt_ch.point_x = '0;
    pt_ch.point_y = '0;
    pt_ch.point_z = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_ROW_COUNT;
    cfg_bus.data = '0;
    image_cfg = '{RST_ROW_COUNT, RST_COLUMN_COUNT, RST_ROWS_PER_RAD, RST_COLS_PER_RAD,
                  RST_ELEV_OFFSET, RST_MIN_RANGE, RST_RANGE_CEIL};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* lidar_range_image_projection_top.f */
sv/lrip_pkg.sv
sv/lrip_if.sv
sv/lrip_front.sv
sv/lrip_queue.sv
sv/lrip_back.sv
sv/lidar_range_image_projection_top.sv
sv/lrip_checker.sv
dv/tb_lidar_range_image_projection_top.sv
